// File: hw/rtl/sha_pkg.sv
// shared types, constants and the rotate function for the sha-256 digest block
`default_nettype none
package sha_pkg;

  localparam int unsigned CntW = 61;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } sha_item_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sha_fifo.sv
// short item queue between the stream front and the compression engine
`default_nettype none
module sha_fifo import sha_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_valid_i,
  output logic           wr_ready_o,
  input  wire sha_item_t wr_item_i,
  output logic           rd_valid_o,
  input  wire logic      rd_ready_i,
  output sha_item_t      rd_item_o
);
  sha_item_t  mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i & wr_ready_o;
  assign rd = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 2'd1;
      if (rd) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("queue overfilled");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 3'd4 |-> !wr) else $error("write into full queue");
  a_no_rd_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 3'd0 |-> !rd) else $error("read from empty queue");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/sha_engine.sv
// byte gathering, padding, 64-round compression and digest word output
`default_nettype none
module sha_engine import sha_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire sha_item_t in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [31:0]    out_word_o,
  output logic [2:0]     out_index_o,
  output logic           out_last_o
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StPad   = 7'b0000010,
    StLoad  = 7'b0000100,
    StRound = 7'b0001000,
    StAdd   = 7'b0010000,
    StLen   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e       st_q, st_d;
  logic [31:0]  wbuf_q [16];
  logic [31:0]  w_q [16];
  logic [31:0]  v_q [8];
  logic [31:0]  h_q [8];
  logic [CntW-1:0] cnt_q;
  logic [5:0]   pos_q;
  logic [5:0]   rnd_q;
  logic         fin_q;
  logic         tail_q;
  logic [2:0]   oi_q;

  logic [31:0] wt, s0, s1, t1, t2, a, e, w15, w2;
  logic [63:0] bits;
  logic        take;

  assign in_ready_o = (st_q == StIdle);
  assign take = in_valid_i & in_ready_o;
  assign bits = {cnt_q, 3'b000};

  assign w15 = w_q[1];
  assign w2  = w_q[14];
  assign s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
  assign s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
  assign wt  = w_q[0];
  assign a   = v_q[0];
  assign e   = v_q[4];
  assign t1  = v_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) +
               ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[rnd_q] + wt;
  assign t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) +
               ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign out_valid_o = (st_q == StOut);
  assign out_word_o  = h_q[oi_q];
  assign out_index_o = oi_q;
  assign out_last_o  = (oi_q == 3'd7);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (take) begin
          if (in_item_i.present && pos_q == 6'd63) st_d = StLoad;
          else if (in_item_i.last) st_d = StPad;
        end
      end
      StPad:   st_d = (pos_q > 6'd55) ? StLoad : StLen;
      StLen:   st_d = StLoad;
      StLoad:  st_d = StRound;
      StRound: if (rnd_q == 6'd63) st_d = StAdd;
      StAdd: begin
        if (!fin_q) st_d = StIdle;
        else if (tail_q) st_d = StOut;
        else if (pos_q == 6'd0) st_d = StPad;
        else st_d = StLen;
      end
      StOut:   if (out_ready_i && oi_q == 3'd7) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take && in_item_i.present)
      wbuf_q[pos_q[5:2]][8*(3-pos_q[1:0]) +: 8] <= in_item_i.data;
    if (st_q == StPad) begin
      for (int i = 0; i < 16; i++)
        for (int b = 0; b < 4; b++)
          if (6'(4*i+b) == pos_q) wbuf_q[i][8*(3-b) +: 8] <= PadByte;
          else if (6'(4*i+b) > pos_q) wbuf_q[i][8*(3-b) +: 8] <= 8'h00;
    end
    if (st_q == StLen) begin
      if (pos_q > 6'd55)
        for (int i = 0; i < 14; i++) wbuf_q[i] <= '0;
      wbuf_q[14] <= bits[63:32];
      wbuf_q[15] <= bits[31:0];
    end
    if (st_q == StLoad) begin
      for (int i = 0; i < 16; i++) w_q[i] <= wbuf_q[i];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (st_q == StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_q[0] + s0 + w_q[9] + s1;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= e;
      v_q[4] <= v_q[3] + t1; v_q[3] <= v_q[2]; v_q[2] <= v_q[1];
      v_q[1] <= a; v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; pos_q <= '0; rnd_q <= '0;
      fin_q <= 1'b0; tail_q <= 1'b0; oi_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else begin
      st_q <= st_d;
      if (take) begin
        fin_q <= in_item_i.last;
        tail_q <= 1'b0;
        if (in_item_i.present) begin
          cnt_q <= cnt_q + CntW'(1);
          pos_q <= pos_q + 6'd1;
        end
      end
      if (st_q == StPad) tail_q <= (pos_q <= 6'd55);
      if (st_q == StLen) tail_q <= 1'b1;
      if (st_q == StLoad) rnd_q <= '0;
      if (st_q == StRound) rnd_q <= rnd_q + 6'd1;
      if (st_q == StAdd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        oi_q <= '0;
      end
      if (st_q == StOut && out_ready_i) begin
        oi_q <= oi_q + 3'd1;
        if (oi_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
          cnt_q <= '0; pos_q <= '0; fin_q <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(oi_q))
    else $error("digest word dropped");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRound && rnd_q == 6'd63 |=> st_q == StAdd) else $error("round count slip");
  a_out_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StOut |-> fin_q && tail_q) else $error("output without finished message");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/sha256_message_digest_top.sv
// top level of the sha-256 byte stream digest block
`default_nettype none
// SHA-256 over a byte stream. Each input transaction may carry one message byte
// (tuser[0] marks it present) and may end the message (tlast). A four-entry queue
// takes transactions while the compression engine works. A byte that fills a
// 64-byte block is followed by load, the 64 rounds of the single round unit and
// add before the engine takes another transaction. Ending a message compresses one
// or two padded blocks, then eight digest words leave most significant first, with
// tuser giving the word index and tlast set on the eighth.
module sha256_message_digest_top import sha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // data_byte
  input  wire logic        s_axis_tuser,  // byte_present
  input  wire logic        s_axis_tlast,  // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // digest_word
  output logic [2:0]       m_axis_tuser,  // word_index
  output logic             m_axis_tlast   // last_word
);
  sha_item_t in_item, q_item;
  logic      q_valid, q_ready;

  assign in_item = '{data: s_axis_tdata, present: s_axis_tuser, last: s_axis_tlast};

  sha_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(s_axis_tvalid), .wr_ready_o(s_axis_tready), .wr_item_i(in_item),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_item_o(q_item)
  );

  sha_engine u_engine (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(m_axis_tdata), .out_index_o(m_axis_tuser), .out_last_o(m_axis_tlast)
  );
endmodule
`default_nettype wire

// File: tb/sv/sha256_message_digest_top_tb.sv
// self-checking testbench for the sha-256 byte stream digest block
`default_nettype none
module sha256_message_digest_top_tb import sha_pkg::*; ();

  typedef struct {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic        typed;
    logic [31:0] word0;
  } stim_row_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [31:0] m_axis_tdata;
  wire logic [2:0]  m_axis_tuser;
  wire logic   m_axis_tlast;

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [60:0] msg_bytes;
  digest_out_t digest_q [$];
  int          errors = 0;
  logic        hold_off = 1'b0;
  logic        sink_done = 1'b0;

  sha256_message_digest_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] rr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, nw;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        nw = w[t & 15]
           + (rr(w[(t-15) & 15], 7) ^ rr(w[(t-15) & 15], 18) ^ (w[(t-15) & 15] >> 3))
           + w[(t-7) & 15]
           + (rr(w[(t-2) & 15], 17) ^ rr(w[(t-2) & 15], 19) ^ (w[(t-2) & 15] >> 10));
        w[t & 15] = nw;
      end
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t & 15];
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic predict_digest(logic [7:0] data, logic present, logic last);
    int unsigned pos;
    logic [63:0] bits;
    digest_out_t d;
    if (present) begin
      pos = msg_bytes[5:0];
      msg_block[pos] = data;
      msg_bytes++;
      if (pos == 63) compress_block();
    end
    if (!last) return;
    pos = msg_bytes[5:0];
    msg_block[pos] = PadByte;
    for (int i = pos + 1; i < 64; i++) msg_block[i] = '0;
    if (pos + 1 > 56) begin
      compress_block();
      for (int i = 0; i < 64; i++) msg_block[i] = '0;
    end
    bits = {msg_bytes, 3'b000};
    for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      d.word = hash_state[i];
      d.index = i[2:0];
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    hash_state = InitHash;
    msg_bytes = '0;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send_item(logic [7:0] data, logic present, logic last, int gap);
    predict_digest(data, present, last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_message(int len, int bias, int noisy, int end_on_byte);
    for (int i = 0; i < len; i++)
      send_item(bias == 0 ? 8'($urandom) : (bias == 1 ? 8'h00 : 8'hff), 1'b1,
                (i == len - 1) && (end_on_byte != 0 || $urandom_range(0, 1) == 1),
                noisy ? gap_len() : 0);
    if (end_on_byte == 0 || len == 0)
      send_item(8'($urandom), (noisy && $urandom_range(0, 3) == 0), 1'b1,
                noisy ? gap_len() : 0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    stim_row_t rows [10];
    rows = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
      '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
      '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
      '{8'h5a, 1'b0, 1'b1, 1'b0, 32'h0},
      '{8'haa, 1'b0, 1'b0, 1'b0, 32'h0},
      '{8'h55, 1'b1, 1'b1, 1'b0, 32'h0}
    };
    hash_state = InitHash;
    msg_bytes = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[r]) begin
      if (rows[r].typed && hash_state[0] == InitHash[0] && msg_bytes <= 3) begin
        send_item(rows[r].data, rows[r].present, rows[r].last, 0);
        if (digest_q[digest_q.size() - 8].word != rows[r].word0) begin
          $error("digest_word row %0d: expected %h, actual %h", r, rows[r].word0,
                 digest_q[digest_q.size() - 8].word);
          errors++;
        end
      end else begin
        send_item(rows[r].data, rows[r].present, rows[r].last, r % 3);
      end
    end
    // padding boundaries: 56 bytes need an extra block, 64 bytes end on a full block
    send_message(56, 1, 0, 1);
    send_message(64, 0, 1, 1);
    wait_drained();
    // receiver held off while the sender keeps offering
    hold_off <= 1'b1;
    send_message(2, 0, 0, 0);
    send_message(0, 0, 0, 0);
    send_message(3, 0, 0, 0);
    send_message(1, 0, 0, 0);
    wait_drained();
    for (int m = 0; m < 3; m++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(8'($urandom), 1'b0, 1'b0, gap_len());
      send_message($urandom_range(0, 8), 0, 1, 0);
    end
    wait_drained();
    repeat (200) @(posedge clk_i);
    sink_done <= 1'b1;
  end

  initial begin
    int n;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    digest_out_t d;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest transaction %h", m_axis_tdata);
        errors++;
      end else begin
        d = digest_q.pop_front();
        if (m_axis_tdata !== d.word) begin
          $error("digest_word: expected %h, actual %h", d.word, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== d.index) begin
          $error("word_index: expected %0d, actual %0d", d.index, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== d.last) begin
          $error("last_word: expected %b, actual %b", d.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    @(posedge sink_done);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
